>>> hdl/rppw_pkg.sv
// ============================================================================
// rppw_pkg
// Types and constants shared by the rotated pixel plane writer.
// ============================================================================
package rppw_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned ADDR_W  = 17;
    localparam int unsigned MASK_W  = 8;
    localparam int unsigned AXIS_W  = 11;  // rotated coordinate, always below 2048
    localparam int unsigned WIDE_W  = 12;  // effective width, up to 2048

    typedef enum logic [1:0] {
        CFG_ROTATION     = 2'd0,
        CFG_PANEL_WIDTH  = 2'd1,
        CFG_PANEL_HEIGHT = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef enum logic [1:0] {
        COLOR_WHITE  = 2'd0,
        COLOR_BLACK  = 2'd1,
        COLOR_RED    = 2'd2,
        COLOR_IGNORE = 2'd3
    } t_color;

    typedef struct packed {
        logic              keep;
        logic [AXIS_W-1:0] ax;
        logic [AXIS_W-1:0] ay;
        logic              bw;
        logic              red;
    } t_pix_map;

endpackage

>>> hdl/rppw_if.sv
// ============================================================================
// rppw_if
// Request and result channels of the rotated pixel plane writer.
// ============================================================================
interface rppw_in_if;
    logic                valid;
    logic                ready;
    logic signed [11:0]  x_coord;
    logic signed [11:0]  y_coord;
    logic [1:0]          pixel_color;

    modport source (output valid, output x_coord, output y_coord, output pixel_color,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input pixel_color,
                    output ready);
endinterface

interface rppw_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] byte_address;
    logic [7:0]  bit_mask;
    logic        bw_bit;
    logic        red_bit;

    modport source (output valid, output byte_address, output bit_mask, output bw_bit,
                    output red_bit, input ready);
    modport sink   (input valid, input byte_address, input bit_mask, input bw_bit,
                    input red_bit, output ready);
endinterface

>>> hdl/rppw_map.sv
// ============================================================================
// rppw_map
// Clips a logical pixel against the rotated panel and maps it to physical
// frame buffer coordinates and plane bit values.
// ============================================================================
module rppw_map (
    input  rppw_pkg::t_rot                    i_rot,
    input  logic [rppw_pkg::WIDE_W-1:0]       i_w,
    input  logic [rppw_pkg::CFG_W-1:0]        i_h,
    input  logic signed [rppw_pkg::COORD_W-1:0] i_x,
    input  logic signed [rppw_pkg::COORD_W-1:0] i_y,
    input  logic [1:0]                        i_color,
    output rppw_pkg::t_pix_map                o_map
);
    import rppw_pkg::*;

    logic [WIDE_W-1:0] xm;
    logic [WIDE_W-1:0] ym;
    logic [WIDE_W-1:0] hw;
    logic [WIDE_W-1:0] lim_x;
    logic [WIDE_W-1:0] lim_y;
    logic [WIDE_W-1:0] ax;
    logic [WIDE_W-1:0] ay;
    logic              inside_panel;
    logic              color_ok;
    logic              bw;
    logic              red;

    assign xm = {1'b0, i_x[COORD_W-2:0]};
    assign ym = {1'b0, i_y[COORD_W-2:0]};
    assign hw = {1'b0, i_h};

    // Quarter turns swap the roles of width and height for the clip limits.
    assign lim_x = (i_rot == ROT_0 || i_rot == ROT_180) ? i_w : hw;
    assign lim_y = (i_rot == ROT_0 || i_rot == ROT_180) ? hw : i_w;

    assign inside_panel = !i_x[COORD_W-1] && !i_y[COORD_W-1] && (xm < lim_x) && (ym < lim_y);

    always_comb begin
        unique case (i_rot)
            ROT_0: begin
                ax = xm;
                ay = ym;
            end
            ROT_90: begin
                ax = i_w - 12'd1 - ym;
                ay = xm;
            end
            ROT_180: begin
                ax = i_w - 12'd1 - xm;
                ay = hw - 12'd1 - ym;
            end
            ROT_270: begin
                ax = ym;
                ay = hw - 12'd1 - xm;
            end
            default: begin
                ax = xm;
                ay = ym;
            end
        endcase
    end

    always_comb begin
        unique case (t_color'(i_color))
            COLOR_WHITE: begin
                color_ok = 1'b1;
                bw       = 1'b1;
                red      = 1'b0;
            end
            COLOR_BLACK: begin
                color_ok = 1'b1;
                bw       = 1'b0;
                red      = 1'b0;
            end
            COLOR_RED: begin
                color_ok = 1'b1;
                bw       = 1'b1;
                red      = 1'b1;
            end
            default: begin
                color_ok = 1'b0;
                bw       = 1'b0;
                red      = 1'b0;
            end
        endcase
    end

    assign o_map.keep = inside_panel && color_ok;
    assign o_map.ax   = ax[AXIS_W-1:0];
    assign o_map.ay   = ay[AXIS_W-1:0];
    assign o_map.bw   = bw;
    assign o_map.red  = red;

endmodule

>>> hdl/rotated_pixel_plane_writer.sv
// ============================================================================
// rotated_pixel_plane_writer
// Maps pixel plot requests to byte address and bit mask of a packed
// 1-bit-per-pixel frame buffer, with rotation and clipping.
// ============================================================================
// Takes one pixel request per clock through a two-register pipeline: the
// input register, then rotation, clipping and the address multiply-add into
// the result register, which a request reaches when the pipeline next
// advances. The whole pipeline advances whenever the result register is
// empty or being taken, so the sustained rate is one request per cycle while
// the receiver keeps taking results. Clipped pixels and the ignored color produce no result.
// Width and height are clamped to MAX_DIM and the width is rounded up to a
// multiple of 8 when the register is written.
// Configuration must only be written while no request is in flight.
module rotated_pixel_plane_writer #(
    parameter int unsigned MAX_DIM = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [rppw_pkg::CFG_W-1:0]  i_cfg_data,
    rppw_in_if.sink                     i_pix,
    rppw_out_if.source                  o_res
);
    import rppw_pkg::*;

    localparam logic [CFG_W+1:0] MAX_DIM_C = (CFG_W+2)'(MAX_DIM);

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] c;
        c = v;
        if ({2'b00, v} > MAX_DIM_C) begin
            c = MAX_DIM_C[CFG_W-1:0];
        end
        return c;
    endfunction

    function automatic logic [WIDE_W-1:0] eff_width(input logic [CFG_W-1:0] v);
        logic [WIDE_W-1:0] s;
        s = {1'b0, clamp_dim(v)} + 12'd7;
        return {s[WIDE_W-1:3], 3'b000};
    endfunction

    // Configuration, stored in its effective form.
    t_rot              r_rot;
    logic [WIDE_W-1:0] r_w;
    logic [CFG_W-1:0]  r_h;

    // Pipeline registers.
    logic                      r_s1_valid;
    logic signed [COORD_W-1:0] r_s1_x;
    logic signed [COORD_W-1:0] r_s1_y;
    logic [1:0]                r_s1_color;
    logic                      r_out_valid;
    logic [ADDR_W-1:0]         r_out_addr;
    logic [MASK_W-1:0]         r_out_mask;
    logic                      r_out_bw;
    logic                      r_out_red;

    logic                      advance;
    t_pix_map                  n_map;
    logic [22:0]               n_sum;

    assign advance   = !r_out_valid || o_res.ready;
    assign i_pix.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= ROT_0;
            r_w   <= eff_width(11'd128);
            r_h   <= clamp_dim(11'd296);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ROTATION:     r_rot <= t_rot'(i_cfg_data[1:0]);
                CFG_PANEL_WIDTH:  r_w   <= eff_width(i_cfg_data);
                CFG_PANEL_HEIGHT: r_h   <= clamp_dim(i_cfg_data);
                default: ;
            endcase
        end
    end

    rppw_map u_map (
        .i_rot   (r_rot),
        .i_w     (r_w),
        .i_h     (r_h),
        .i_x     (r_s1_x),
        .i_y     (r_s1_y),
        .i_color (r_s1_color),
        .o_map   (n_map)
    );

    // The product stays below 2^22, so the sum fits in 23 bits before the shift.
    assign n_sum = 23'(n_map.ay * r_w) + 23'(n_map.ax);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_pix.valid;
            r_out_valid <= r_s1_valid && n_map.keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_x     <= i_pix.x_coord;
            r_s1_y     <= i_pix.y_coord;
            r_s1_color <= i_pix.pixel_color;
            r_out_addr <= n_sum[ADDR_W+2:3];
            r_out_mask <= 8'h80 >> n_map.ax[2:0];
            r_out_bw   <= n_map.bw;
            r_out_red  <= n_map.red;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.byte_address = r_out_addr;
    assign o_res.bit_mask     = r_out_mask;
    assign o_res.bw_bit       = r_out_bw;
    assign o_res.red_bit      = r_out_red;

endmodule

>>> dv/tb_rotated_pixel_plane_writer.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_rotated_pixel_plane_writer
// Self-checking testbench for the rotated pixel plane writer.
// ============================================================================
// Pixel requests go in through the request channel. Each accepted request is
// mapped by a local predictor to its frame buffer byte, bit mask and plane
// bits, and the plots coming out are compared in order against that
// prediction. The directed tests cover the color codes, the corners of each
// rotation and the extreme panel sizes. The random test runs many panel
// settings. Both channels idle at random, and the receiver is once held off
// long enough for the block to fill up and stall its input.
// ============================================================================
module tb_rotated_pixel_plane_writer;
    import rppw_pkg::*;

    localparam int DIM_LIMIT     = 1024;
    localparam int SETTLE_CYCLES = 10;    // pipeline is two stages deep
    localparam int STALL_LIMIT   = 2000;  // cycles with no request and no plot taken
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [MASK_W-1:0] bit_mask;
        logic              bw_bit;
        logic              red_bit;
    } t_plot;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    rppw_in_if  pix_if ();
    rppw_out_if res_if ();

    rotated_pixel_plane_writer #(
        .MAX_DIM (DIM_LIMIT)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    // Local copy of the panel settings.
    t_rot           rot_cfg;
    logic [CFG_W-1:0] width_cfg;
    logic [CFG_W-1:0] height_cfg;

    t_plot pending_plots[$];
    int    mismatches;
    int    requests_sent;
    int    plots_checked;
    int    settings_applied;
    int    idle_cycles;
    int    hold_cycles;
    bit    send_gaps;
    bit    recv_gaps;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int eff_width();
        int w;
        w = (width_cfg > DIM_LIMIT) ? DIM_LIMIT : int'(width_cfg);
        return (w + 7) / 8 * 8;
    endfunction

    function automatic int eff_height();
        return (height_cfg > DIM_LIMIT) ? DIM_LIMIT : int'(height_cfg);
    endfunction

    // Returns 1 when the pixel lands on the panel with a drawable color.
    function automatic bit map_pixel(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y,
                                     input t_color color, output t_plot plot);
        int w, h, lim_x, lim_y, ax, ay;
        logic [31:0] addr;
        plot = '0;
        case (color)
            COLOR_WHITE: begin
                plot.bw_bit = 1'b1;
                plot.red_bit = 1'b0;
            end
            COLOR_BLACK: begin
                plot.bw_bit = 1'b0;
                plot.red_bit = 1'b0;
            end
            COLOR_RED: begin
                plot.bw_bit = 1'b1;
                plot.red_bit = 1'b1;
            end
            default: return 1'b0;
        endcase
        w = eff_width();
        h = eff_height();
        if (rot_cfg == ROT_0 || rot_cfg == ROT_180) begin
            lim_x = w;
            lim_y = h;
        end else begin
            lim_x = h;
            lim_y = w;
        end
        if (x < 0 || x >= lim_x || y < 0 || y >= lim_y) return 1'b0;
        case (rot_cfg)
            ROT_0: begin
                ax = x;
                ay = y;
            end
            ROT_90: begin
                ax = w - 1 - y;
                ay = x;
            end
            ROT_180: begin
                ax = w - 1 - x;
                ay = h - 1 - y;
            end
            default: begin
                ax = y;
                ay = h - 1 - x;
            end
        endcase
        addr = (ax + ay * w) / 8;
        plot.byte_address = addr[ADDR_W-1:0];
        plot.bit_mask = 8'h80 >> ax[2:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: plot %0d %s mismatch: got 0x%0h, expected 0x%0h",
                 $time, plots_checked, field, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROTATION:     rot_cfg = t_rot'(value[1:0]);
            CFG_PANEL_WIDTH:  width_cfg = value;
            CFG_PANEL_HEIGHT: height_cfg = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input t_color color);
        int    gap;
        t_plot plot;
        gap = send_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.x_coord     <= x;
        pix_if.y_coord     <= y;
        pix_if.pixel_color <= color;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        if (map_pixel(x, y, color, plot)) pending_plots.push_back(plot);
        requests_sent++;
    endtask

    // Clipped requests leave no trace in the queue, so let the pipeline settle
    // after the queue drains, before anything touches the configuration.
    task automatic settle_pipeline();
        pix_if.valid <= 1'b0;
        while (pending_plots.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(input int lim);
        int mode;
        mode = $urandom_range(0, 19);
        if (lim > 0 && mode < 14) return COORD_W'($urandom_range(0, lim - 1));
        if (mode < 16) return COORD_W'(lim - 2 + int'($urandom_range(0, 3)));
        if (mode < 17) return COORD_W'(int'($urandom_range(0, 2)) - 1);
        return COORD_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_dimension(input int lo);
        int mode;
        mode = $urandom_range(0, 7);
        if (mode == 0) return CFG_W'($urandom_range(0, 2047));
        if (mode == 1) return CFG_W'($urandom_range(1000, 1040));
        return CFG_W'($urandom_range(lo, 160));
    endfunction

    task automatic test_color_codes();
        send_pixel(12'sd0, 12'sd0, COLOR_WHITE);
        send_pixel(12'sd127, 12'sd295, COLOR_BLACK);
        send_pixel(12'sd5, 12'sd3, COLOR_RED);
        send_pixel(12'sd5, 12'sd3, COLOR_IGNORE);
        send_pixel(12'sd128, 12'sd0, COLOR_WHITE);
        send_pixel(12'sd0, 12'sd296, COLOR_RED);
        send_pixel(-12'sd1, 12'sd0, COLOR_BLACK);
        send_pixel(-12'sd2048, 12'sd2047, COLOR_WHITE);
        send_pixel(12'sd2047, -12'sd2048, COLOR_RED);
        settle_pipeline();
    endtask

    task automatic test_rotation_corners();
        int r, lim_x, lim_y;
        // A width of 13 is rounded up to 16.
        write_reg(CFG_PANEL_WIDTH, 11'd13);
        write_reg(CFG_PANEL_HEIGHT, 11'd10);
        for (r = 0; r < 4; r++) begin
            write_reg(CFG_ROTATION, 11'(r));
            settings_applied++;
            lim_x = (r % 2 == 0) ? 16 : 10;
            lim_y = (r % 2 == 0) ? 10 : 16;
            send_pixel(12'sd0, 12'sd0, COLOR_WHITE);
            send_pixel(12'(lim_x - 1), 12'(lim_y - 1), COLOR_RED);
            if (r < 2) send_pixel(12'(lim_x), 12'sd0, COLOR_BLACK);
            else       send_pixel(12'sd0, 12'(lim_y), COLOR_BLACK);
            settle_pipeline();
        end
    endtask

    task automatic test_panel_extremes();
        // Oversized registers clamp to the largest panel, whose last byte is
        // the top of the address range.
        write_reg(CFG_ROTATION, 11'(ROT_0));
        write_reg(CFG_PANEL_WIDTH, 11'd2047);
        write_reg(CFG_PANEL_HEIGHT, 11'd2047);
        send_pixel(12'sd1023, 12'sd1023, COLOR_BLACK);
        send_pixel(12'sd1024, 12'sd1023, COLOR_WHITE);
        settle_pipeline();
        write_reg(CFG_PANEL_WIDTH, 11'd0);
        send_pixel(12'sd0, 12'sd0, COLOR_WHITE);
        settle_pipeline();
        write_reg(CFG_PANEL_WIDTH, 11'd8);
        write_reg(CFG_PANEL_HEIGHT, 11'd0);
        send_pixel(12'sd0, 12'sd0, COLOR_RED);
        settle_pipeline();
        write_reg(CFG_PANEL_WIDTH, 11'd1);
        write_reg(CFG_PANEL_HEIGHT, 11'd1);
        send_pixel(12'sd7, 12'sd0, COLOR_RED);
        send_pixel(12'sd0, 12'sd1, COLOR_BLACK);
        settle_pipeline();
        settings_applied += 4;
    endtask

    task automatic test_output_backpressure();
        int n;
        write_reg(CFG_ROTATION, 11'(ROT_90));
        write_reg(CFG_PANEL_WIDTH, 11'd64);
        write_reg(CFG_PANEL_HEIGHT, 11'd32);
        settings_applied++;
        send_gaps = 1'b0;
        hold_cycles = HOLD_CYCLES;
        for (n = 0; n < 40; n++) begin
            send_pixel(12'($urandom_range(0, 31)), 12'($urandom_range(0, 63)),
                       t_color'($urandom_range(0, 2)));
        end
        settle_pipeline();
        send_gaps = 1'b1;
    endtask

    task automatic test_random_plots();
        int phase, n, lim_x, lim_y;
        for (phase = 0; phase < 11; phase++) begin
            send_gaps = (phase % 3 != 0);
            recv_gaps = (phase % 4 != 1);
            write_reg(CFG_ROTATION, 11'($urandom_range(0, 3)));
            write_reg(CFG_PANEL_WIDTH, pick_dimension(8));
            write_reg(CFG_PANEL_HEIGHT, pick_dimension(1));
            settings_applied++;
            lim_x = (rot_cfg == ROT_0 || rot_cfg == ROT_180) ? eff_width() : eff_height();
            lim_y = (rot_cfg == ROT_0 || rot_cfg == ROT_180) ? eff_height() : eff_width();
            for (n = 0; n < 100; n++) begin
                send_pixel(pick_coord(lim_x), pick_coord(lim_y),
                           t_color'($urandom_range(0, 3)));
            end
            settle_pipeline();
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    // Plot receiver: a random stall before each plot while receive gaps are
    // enabled, plus a long hold-off whenever a test asks for one.
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                while (hold_cycles > 0) begin
                    @(posedge i_clk);
                    hold_cycles--;
                end
            end
            stall = recv_gaps ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid && hold_cycles == 0) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_plot want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_plots.size() == 0) begin
                $display("%0t: plot at byte 0x%0h with no request waiting for it",
                         $time, res_if.byte_address);
                mismatches++;
            end else begin
                want = pending_plots.pop_front();
                if (res_if.byte_address !== want.byte_address)
                    report_mismatch("byte_address", res_if.byte_address, want.byte_address);
                if (res_if.bit_mask !== want.bit_mask)
                    report_mismatch("bit_mask", res_if.bit_mask, want.bit_mask);
                if (res_if.bw_bit !== want.bw_bit)
                    report_mismatch("bw_bit", res_if.bw_bit, want.bw_bit);
                if (res_if.red_bit !== want.red_bit)
                    report_mismatch("red_bit", res_if.red_bit, want.red_bit);
            end
            plots_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_ROTATION;
        i_cfg_data         <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.x_coord     <= '0;
        pix_if.y_coord     <= '0;
        pix_if.pixel_color <= COLOR_WHITE;
        rot_cfg            = ROT_0;
        width_cfg          = 11'd128;
        height_cfg         = 11'd296;
        mismatches         = 0;
        requests_sent      = 0;
        plots_checked      = 0;
        settings_applied   = 1;
        idle_cycles        = 0;
        hold_cycles        = 0;
        send_gaps          = 1'b1;
        recv_gaps          = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_color_codes();
        test_rotation_corners();
        test_panel_extremes();
        test_output_backpressure();
        test_random_plots();

        $display("Sent %0d pixel requests under %0d panel settings and checked %0d plots.",
                 requests_sent, settings_applied, plots_checked);
        $display("Covered all color codes, all rotations, clipping on every edge, "
                 , "clamped and empty panels, and a long receiver hold-off.");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> rotated_pixel_plane_writer.f
hdl/rppw_pkg.sv
hdl/rppw_if.sv
hdl/rppw_map.sv
hdl/rotated_pixel_plane_writer.sv
dv/tb_rotated_pixel_plane_writer.sv
